// ----- hdl/esc_pkg.sv -----
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants of the environment sensor compensation
// Sequencer states, register indexes, special codes and sign-extension helpers.
// ----------------------------------------------------------------------------
package esc_pkg;

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_T0, ST_T1, ST_T2, ST_T3,
      ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7,
      ST_DIV,
      ST_P8, ST_P9, ST_P10, ST_P11,
      ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7, ST_H8,
      ST_MULP, ST_MUL,
      ST_FIN
   } state_type;

   typedef enum logic [2:0] {
      CSR_TEMP_TRIM    = 3'd0,
      CSR_PRESS_TRIM_A = 3'd1,
      CSR_PRESS_TRIM_B = 3'd2,
      CSR_PRESS_TRIM_C = 3'd3,
      CSR_HUM_TRIM_A   = 3'd4,
      CSR_HUM_TRIM_B   = 3'd5
   } csr_index_type;

   localparam logic [23:0] DIS_WIDE  = 24'h800000;
   localparam logic [15:0] DIS_HUM   = 16'h8000;
   localparam logic [31:0] SAT_OUT   = 32'h7FFF_FFFF;
   localparam logic [5:0]  MUL_LAST  = 6'd31;   // radix-4 steps over 64 bits
   localparam logic [5:0]  DIV_LAST  = 6'd63;   // one quotient bit per step
   localparam logic [31:0] HUM_CLAMP = 32'd419430400;

   function automatic logic [63:0] sx8(input logic [7:0] v);
      return {{56{v[7]}}, v};
   endfunction

   function automatic logic [63:0] sx12(input logic [11:0] v);
      return {{52{v[11]}}, v};
   endfunction

   function automatic logic [63:0] sx16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [63:0] sx32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

endpackage

// ----- hdl/env_sensor_compensation.sv -----
// ----------------------------------------------------------------------------
// env_sensor_compensation: integer compensation of temperature, pressure and
// humidity samples using factory trim coefficients.
// ----------------------------------------------------------------------------
// One raw sample is taken per transfer on the req_ channel, and one result
// comes out on the rsp_ channel. Work runs on a single shared 64-bit radix-4
// shift-add multiplier (2 bits per cycle, with a setup step for each product) and a
// restoring divider that reuses the multiplier's registers (one quotient bit
// per cycle). With all three channels enabled, the work from one sample transfer
// to the next is 21 products, one division and one step for each sequencer state.
// Disabled channels skip their products, and a zero pressure divisor skips the
// division. req_stall stays high while an item is in progress; a finished
// result sits in the output register while the next sample is taken.
// Temperature updates the stored fine temperature; a disabled temperature
// keeps the previous value for pressure and humidity. Trim registers must be
// written through csr_ only while the block is idle; this is not enforced.
// ----------------------------------------------------------------------------
module env_sensor_compensation
   import esc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // sample channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [23:0]        req_raw_temperature,
   input  logic [23:0]        req_raw_pressure,
   input  logic [15:0]        req_raw_humidity,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_temperature,
   output logic signed [31:0] rsp_pressure,
   output logic [30:0]        rsp_humidity,
   // trim register writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data
);

   // trim registers
   logic [47:0] temp_trim_ff;
   logic [63:0] press_a_ff, press_b_ff;
   logic [15:0] press_c_ff;
   logic [31:0] hum_a_ff, hum_b_ff;

   // sequencer
   state_type state_ff, state_in, ret_ff, ret_in;
   logic [5:0] cnt_ff, cnt_in;

   // captured sample
   logic [23:0] rt_ff, rp_ff;
   logic [15:0] rh_ff;

   // shared multiplier / divider registers
   logic [63:0] ma_ff, ma_in, mb_ff, mb_in, a3_ff, a3_in, acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic [63:0] mul_a, mul_b;

   // working registers
   logic [63:0] x_ff, x_in, y_ff, y_in, z_ff, z_in, w_ff, w_in, d_ff, d_in;
   logic [31:0] fine_ff, fine_in;
   logic [31:0] res_t_ff, res_t_in, res_p_ff, res_p_in;
   logic [30:0] res_h_ff, res_h_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] out_t_ff, out_t_in, out_p_ff, out_p_in;
   logic [30:0] out_h_ff, out_h_in;

   logic t_dis, p_dis, h_dis, out_free;

   assign t_dis    = (rt_ff == DIS_WIDE);
   assign p_dis    = (rp_ff == DIS_WIDE);
   assign h_dis    = (rh_ff == DIS_HUM);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall       = (state_ff != ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temperature = out_t_ff;
   assign rsp_pressure    = out_p_ff;
   assign rsp_humidity    = out_h_ff;

   // ---------------------------------------------------------------------
   // Trim fields
   // ---------------------------------------------------------------------
   logic [63:0] t1, t2, t3;
   logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [63:0] h1, h2, h3, h4, h5, h6;

   assign t1 = {48'b0, temp_trim_ff[15:0]};
   assign t2 = sx16(temp_trim_ff[31:16]);
   assign t3 = sx16(temp_trim_ff[47:32]);
   assign p1 = {48'b0, press_a_ff[15:0]};
   assign p2 = sx16(press_a_ff[31:16]);
   assign p3 = sx16(press_a_ff[47:32]);
   assign p4 = sx16(press_a_ff[63:48]);
   assign p5 = sx16(press_b_ff[15:0]);
   assign p6 = sx16(press_b_ff[31:16]);
   assign p7 = sx16(press_b_ff[47:32]);
   assign p8 = sx16(press_b_ff[63:48]);
   assign p9 = sx16(press_c_ff);
   assign h1 = {56'b0, hum_a_ff[7:0]};
   assign h2 = sx16(hum_a_ff[23:8]);
   assign h3 = {56'b0, hum_a_ff[31:24]};
   assign h4 = sx12(hum_b_ff[11:0]);
   assign h5 = sx12(hum_b_ff[23:12]);
   assign h6 = sx8(hum_b_ff[31:24]);

   // ---------------------------------------------------------------------
   // Datapath terms from the product register
   // ---------------------------------------------------------------------
   logic [63:0] adc, acc_asr8, acc_asr11, acc_asr12, acc_asr14, acc_asr19;
   logic [63:0] acc_asr25, acc_asr33, y_asr13, p_sum, p_final;
   logic [31:0] acc32, hx, ha1, ha2, hc, hd, he, hf;
   logic [31:0] hs4, hs10, hs11;
   logic [63:0] pp;

   assign adc       = {44'b0, rt_ff[23:4]};
   assign acc_asr8  = $signed(acc_ff) >>> 8;
   assign acc_asr11 = $signed(acc_ff) >>> 11;
   assign acc_asr12 = $signed(acc_ff) >>> 12;
   assign acc_asr14 = $signed(acc_ff) >>> 14;
   assign acc_asr19 = $signed(acc_ff) >>> 19;
   assign acc_asr25 = $signed(acc_ff) >>> 25;
   assign acc_asr33 = $signed(acc_ff) >>> 33;
   assign y_asr13   = $signed(y_ff) >>> 13;
   assign pp        = 64'd1048576 - {44'b0, rp_ff[23:4]};
   assign p_sum     = $signed(y_ff + w_ff + acc_asr19) >>> 8;
   assign p_final   = p_sum + (p7 << 4);

   // arithmetic shifts of the low product word, kept apart from unsigned sums
   assign acc32 = acc_ff[31:0];
   assign hs4   = $signed(acc32) >>> 4;
   assign hs10  = $signed(acc32) >>> 10;
   assign hs11  = $signed(acc32) >>> 11;
   assign hx    = fine_ff - 32'd76800;
   assign ha1   = {rh_ff, 14'b0} - (h4[31:0] << 20) - acc32;
   assign ha2   = $signed(ha1 + 32'd16384) >>> 15;
   assign hc    = hs11 + 32'd32768;
   assign hd    = hs10 + 32'd2097152;
   assign he    = $signed(acc32 + 32'd8192) >>> 14;
   assign hf    = w_ff[31:0] - hs4;

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_T0;
         ST_T0: begin
            if (t_dis) begin
               state_in = ST_P0;
            end else begin
               state_in = ST_MULP; ret_in = ST_T1;
            end
         end
         ST_T1:  begin state_in = ST_MULP; ret_in = ST_T2; end
         ST_T2:  begin state_in = ST_MULP; ret_in = ST_T3; end
         ST_T3:  state_in = ST_P0;
         ST_P0: begin
            if (p_dis) begin
               state_in = ST_H0;
            end else begin
               state_in = ST_MULP; ret_in = ST_P1;
            end
         end
         ST_P1:  begin state_in = ST_MULP; ret_in = ST_P2; end
         ST_P2:  begin state_in = ST_MULP; ret_in = ST_P3; end
         ST_P3:  begin state_in = ST_MULP; ret_in = ST_P4; end
         ST_P4:  begin state_in = ST_MULP; ret_in = ST_P5; end
         ST_P5:  begin state_in = ST_MULP; ret_in = ST_P6; end
         ST_P6: begin
            if (acc_asr33 == 64'd0) begin
               state_in = ST_H0;
            end else begin
               state_in = ST_MULP; ret_in = ST_P7;
            end
         end
         ST_P7:  state_in = ST_DIV;
         ST_DIV: if (cnt_ff == DIV_LAST) state_in = ST_P8;
         ST_P8:  begin state_in = ST_MULP; ret_in = ST_P9; end
         ST_P9:  begin state_in = ST_MULP; ret_in = ST_P10; end
         ST_P10: begin state_in = ST_MULP; ret_in = ST_P11; end
         ST_P11: state_in = ST_H0;
         ST_H0: begin
            if (h_dis) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_MULP; ret_in = ST_H1;
            end
         end
         ST_H1:  begin state_in = ST_MULP; ret_in = ST_H2; end
         ST_H2:  begin state_in = ST_MULP; ret_in = ST_H3; end
         ST_H3:  begin state_in = ST_MULP; ret_in = ST_H4; end
         ST_H4:  begin state_in = ST_MULP; ret_in = ST_H5; end
         ST_H5:  begin state_in = ST_MULP; ret_in = ST_H6; end
         ST_H6:  begin state_in = ST_MULP; ret_in = ST_H7; end
         ST_H7:  begin state_in = ST_MULP; ret_in = ST_H8; end
         ST_H8:  state_in = ST_FIN;
         ST_MULP: state_in = ST_MUL;
         ST_MUL: if (cnt_ff == MUL_LAST) state_in = ret_ff;
         ST_FIN: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Multiplier operand select for the step that launches a product
   // ---------------------------------------------------------------------
   always_comb begin
      mul_a = 64'd0;
      mul_b = 64'd0;
      unique case (state_ff)
         ST_T0:  begin mul_a = (adc >> 3) - (t1 << 1); mul_b = t2; end
         ST_T1:  begin mul_a = (adc >> 4) - t1; mul_b = (adc >> 4) - t1; end
         ST_T2:  begin mul_a = acc_asr12; mul_b = t3; end
         ST_P0:  begin
            mul_a = sx32(fine_ff) - 64'd128000;
            mul_b = sx32(fine_ff) - 64'd128000;
         end
         ST_P1:  begin mul_a = acc_ff; mul_b = p6; end
         ST_P2:  begin mul_a = x_ff; mul_b = p5; end
         ST_P3:  begin mul_a = y_ff; mul_b = p3; end
         ST_P4:  begin mul_a = x_ff; mul_b = p2; end
         ST_P5:  begin mul_a = w_ff + (acc_ff << 12) + (64'd1 << 47); mul_b = p1; end
         ST_P6:  begin mul_a = (pp << 31) - z_ff; mul_b = 64'd3125; end
         ST_P8:  begin
            mul_a = p9;
            mul_b = $signed(neg_ff ? (64'd0 - ma_ff) : ma_ff) >>> 13;
         end
         ST_P9:  begin mul_a = acc_ff; mul_b = y_asr13; end
         ST_P10: begin mul_a = p8; mul_b = y_ff; end
         ST_H0:  begin mul_a = h5; mul_b = sx32(hx); end
         ST_H1:  begin mul_a = x_ff; mul_b = h6; end
         ST_H2:  begin mul_a = x_ff; mul_b = h3; end
         ST_H3:  begin mul_a = z_ff; mul_b = sx32(hc); end
         ST_H4:  begin mul_a = sx32(hd); mul_b = h2; end
         ST_H5:  begin mul_a = y_ff; mul_b = sx32(he); end
         ST_H6:  begin
            mul_a = sx32($signed(acc32) >>> 15);
            mul_b = sx32($signed(acc32) >>> 15);
         end
         ST_H7:  begin mul_a = sx32($signed(acc32) >>> 7); mul_b = h1; end
         default: begin mul_a = 64'd0; mul_b = 64'd0; end
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath next values
   // ---------------------------------------------------------------------
   logic [63:0] addend;
   logic [64:0] rem_sh;
   logic [65:0] rem_diff;
   logic        rem_ge;
   logic [31:0] hum_clamped;

   always_comb begin
      unique case (mb_ff[1:0])
         2'd0: addend = 64'd0;
         2'd1: addend = ma_ff;
         2'd2: addend = ma_ff << 1;
         2'd3: addend = a3_ff;
         default: addend = 64'd0;
      endcase
      rem_sh   = {acc_ff, ma_ff[63]};
      rem_diff = {1'b0, rem_sh} - {2'b0, mb_ff};
      rem_ge   = !rem_diff[65];
      priority if (hf[31])          hum_clamped = 32'd0;
      else if (hf > HUM_CLAMP)      hum_clamped = HUM_CLAMP;
      else                          hum_clamped = hf;
   end

   always_comb begin
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      a3_in    = a3_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      w_in     = w_ff;
      d_in     = d_ff;
      fine_in  = fine_ff;
      res_t_in = res_t_ff;
      res_p_in = res_p_ff;
      res_h_in = res_h_ff;
      out_t_in = out_t_ff;
      out_p_in = out_p_ff;
      out_h_in = out_h_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_T0:  if (t_dis) res_t_in = SAT_OUT;
         ST_T1:  w_in = acc_asr11;
         ST_T3:  fine_in = w_ff[31:0] + acc_asr14[31:0];
         ST_P0: begin
            if (!t_dis) res_t_in = (fine_ff << 2) + fine_ff + 32'd128;
            if (p_dis) res_p_in = SAT_OUT;
            x_in = sx32(fine_ff) - 64'd128000;
         end
         ST_P1:  y_in = acc_ff;
         ST_P2:  z_in = acc_ff;
         ST_P3:  z_in = z_ff + (acc_ff << 17) + (p4 << 35);
         ST_P4:  w_in = acc_asr8;
         ST_P6: begin
            d_in = acc_asr33;
            if (acc_asr33 == 64'd0) res_p_in = 32'd0;
         end
         ST_P7: begin
            // divide on magnitudes, fix the sign at the end
            neg_in = acc_ff[63] ^ d_ff[63];
            ma_in  = acc_ff[63] ? (64'd0 - acc_ff) : acc_ff;
            mb_in  = d_ff[63] ? (64'd0 - d_ff) : d_ff;
            acc_in = 64'd0;
            cnt_in = 6'd0;
         end
         ST_DIV: begin
            acc_in = rem_ge ? rem_diff[63:0] : rem_sh[63:0];
            ma_in  = {ma_ff[62:0], rem_ge};
            cnt_in = cnt_ff + 6'd1;
         end
         ST_P8:  y_in = neg_ff ? (64'd0 - ma_ff) : ma_ff;
         ST_P10: w_in = acc_asr25;
         ST_P11: res_p_in = p_final[31:0];
         ST_H0: begin
            if (h_dis) res_h_in = SAT_OUT[30:0];
            x_in = sx32(hx);
         end
         ST_H1:  y_in = sx32(ha2);
         ST_H2:  z_in = sx32($signed(acc32) >>> 10);
         ST_H6:  w_in = sx32(acc32);
         ST_H8:  res_h_in = hum_clamped[30:0] >> 12;
         ST_MULP: a3_in = ma_ff + (ma_ff << 1);
         ST_MUL: begin
            acc_in = acc_ff + addend;
            ma_in  = ma_ff << 2;
            a3_in  = a3_ff << 2;
            mb_in  = mb_ff >> 2;
            cnt_in = cnt_ff + 6'd1;
         end
         ST_FIN: begin
            if (out_free) begin
               out_t_in     = res_t_ff;
               out_p_in     = res_p_ff;
               out_h_in     = res_h_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase

      // product launch
      if (state_in == ST_MULP) begin
         ma_in  = mul_a;
         mb_in  = mul_b;
         acc_in = 64'd0;
         cnt_in = 6'd0;
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fine_ff      <= 32'd0;
         temp_trim_ff <= 48'd0;
         press_a_ff   <= 64'd0;
         press_b_ff   <= 64'd0;
         press_c_ff   <= 16'd0;
         hum_a_ff     <= 32'd0;
         hum_b_ff     <= 32'd0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         fine_ff      <= fine_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_TEMP_TRIM:    temp_trim_ff <= csr_data[47:0];
               CSR_PRESS_TRIM_A: press_a_ff   <= csr_data;
               CSR_PRESS_TRIM_B: press_b_ff   <= csr_data;
               CSR_PRESS_TRIM_C: press_c_ff   <= csr_data[15:0];
               CSR_HUM_TRIM_A:   hum_a_ff     <= csr_data[31:0];
               CSR_HUM_TRIM_B:   hum_b_ff     <= csr_data[31:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         rt_ff <= req_raw_temperature;
         rp_ff <= req_raw_pressure;
         rh_ff <= req_raw_humidity;
      end
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      a3_ff    <= a3_in;
      acc_ff   <= acc_in;
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      w_ff     <= w_in;
      d_ff     <= d_in;
      res_t_ff <= res_t_in;
      res_p_ff <= res_p_in;
      res_h_ff <= res_h_in;
      out_t_ff <= out_t_in;
      out_p_ff <= out_p_in;
      out_h_ff <= out_h_in;
   end

endmodule

// ----- hdl/esc_checker.sv -----
// ----------------------------------------------------------------------------
// esc_assertions: port-level checks of the environment sensor compensation
// Watches the sample, result and trim ports over time.
// ----------------------------------------------------------------------------
module esc_assertions
   import esc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [23:0]        req_raw_temperature,
   input logic [23:0]        req_raw_pressure,
   input logic [15:0]        req_raw_humidity,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_temperature,
   input logic signed [31:0] rsp_pressure,
   input logic [30:0]        rsp_humidity,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic [2:0]         csr_index,
   input logic [63:0]        csr_data
);

   // a sample transfer always makes the block busy
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block not busy after sample transfer");

   // a new result only appears as the sequencer finishes
   a_result_at_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while idle");

   // humidity is clamped or flagged as disabled
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_humidity <= 31'd102400 || rsp_humidity == SAT_OUT[30:0]))
      else $error("humidity out of range");

   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_temperature)
         && $stable(rsp_pressure) && $stable(rsp_humidity)))
      else $error("stalled result changed");

endmodule

bind env_sensor_compensation esc_assertions u_esc_assertions (.*);
